/* design/nlc_pkg.sv */
package nlc_pkg;

    // default token length limit, sets the position saturation point
    localparam int NLC_MAX_TOKEN_LEN_DEF = 64;

    // field widths of the beats
    localparam int NLC_CH_W    = 8;
    localparam int NLC_RADIX_W = 2;
    localparam int NLC_OFS_W   = 2;
    localparam int NLC_ERR_W   = 3;
    localparam int NLC_POS_W   = 6;

    // largest position the counter can show
    localparam int NLC_POS_MAX = (1 << NLC_POS_W) - 1;

    // offset reported when a two-character prefix is skipped
    localparam logic [NLC_OFS_W-1:0] NLC_OFS_NONE   = 2'd0;
    localparam logic [NLC_OFS_W-1:0] NLC_OFS_PREFIX = 2'd2;

    // characters of interest
    localparam logic [NLC_CH_W-1:0] CH_ZERO  = 8'h30;
    localparam logic [NLC_CH_W-1:0] CH_ONE   = 8'h31;
    localparam logic [NLC_CH_W-1:0] CH_SEVEN = 8'h37;
    localparam logic [NLC_CH_W-1:0] CH_NINE  = 8'h39;
    localparam logic [NLC_CH_W-1:0] CH_LO_X  = 8'h78;
    localparam logic [NLC_CH_W-1:0] CH_UP_X  = 8'h58;
    localparam logic [NLC_CH_W-1:0] CH_LO_B  = 8'h62;
    localparam logic [NLC_CH_W-1:0] CH_UP_B  = 8'h42;
    localparam logic [NLC_CH_W-1:0] CH_LO_E  = 8'h65;
    localparam logic [NLC_CH_W-1:0] CH_UP_E  = 8'h45;
    localparam logic [NLC_CH_W-1:0] CH_LO_A  = 8'h61;
    localparam logic [NLC_CH_W-1:0] CH_LO_F  = 8'h66;
    localparam logic [NLC_CH_W-1:0] CH_LO_Z  = 8'h7a;
    localparam logic [NLC_CH_W-1:0] CH_UP_A  = 8'h41;
    localparam logic [NLC_CH_W-1:0] CH_UP_F  = 8'h46;
    localparam logic [NLC_CH_W-1:0] CH_UP_Z  = 8'h5a;
    localparam logic [NLC_CH_W-1:0] CH_DOT   = 8'h2e;
    localparam logic [NLC_CH_W-1:0] CH_PLUS  = 8'h2b;
    localparam logic [NLC_CH_W-1:0] CH_MINUS = 8'h2d;

    typedef enum logic [3:0] {
        PH_FIRST,
        PH_ZERO,
        PH_MAIN,
        PH_SIGNDIG,
        PH_FRAC,
        PH_EXPSTART,
        PH_EXPSIGN,
        PH_EXPDIG,
        PH_DONE
    } phase_t;

    typedef enum logic [NLC_RADIX_W-1:0] {
        RX_BIN,
        RX_OCT,
        RX_DEC,
        RX_HEX
    } radix_t;

    typedef enum logic [NLC_ERR_W-1:0] {
        ERR_NONE,
        ERR_BAD_BIN,
        ERR_BAD_OCT,
        ERR_BAD_DEC,
        ERR_EXP_EMPTY,
        ERR_FLOAT_SUFFIX,
        ERR_INT_SUFFIX
    } err_t;

    // token scan state
    typedef struct packed {
        phase_t                phase;
        radix_t                radix;
        logic                  is_float;
        logic                  force_fp;
        logic [NLC_POS_W-1:0]  position;
        logic [NLC_OFS_W-1:0]  offset;
        err_t                  err_code;
        logic [NLC_POS_W-1:0]  err_pos;
        logic [NLC_POS_W-1:0]  exp_pos;
    } scan_state_t;

    // classification of one finished token
    typedef struct packed {
        radix_t                radix;
        logic                  is_float;
        logic [NLC_OFS_W-1:0]  offset;
        err_t                  err_code;
        logic [NLC_POS_W-1:0]  err_pos;
    } result_t;

    localparam scan_state_t SCAN_RESET = '{
        phase:    PH_FIRST,
        radix:    RX_BIN,
        is_float: 1'b0,
        force_fp: 1'b0,
        position: '0,
        offset:   NLC_OFS_NONE,
        err_code: ERR_NONE,
        err_pos:  '0,
        exp_pos:  '0
    };

endpackage

/* design/nlc_if.sv */
// character beats into the classifier
interface nlc_in_if
    import nlc_pkg::*;
();
    logic                 valid;
    logic                 ready;
    logic [NLC_CH_W-1:0]  ch;
    logic                 is_last;
    logic                 fp_force;

    modport source (output valid, output ch, output is_last, output fp_force,
                    input ready);
    modport sink   (input valid, input ch, input is_last, input fp_force,
                    output ready);
endinterface

// result beats out of the classifier
interface nlc_out_if
    import nlc_pkg::*;
();
    logic                    valid;
    logic                    ready;
    logic [NLC_RADIX_W-1:0]  radix_code;
    logic                    float_flag;
    logic [NLC_OFS_W-1:0]    digits_offset;
    logic [NLC_ERR_W-1:0]    error_code;
    logic [NLC_POS_W-1:0]    error_pos;

    modport source (output valid, output radix_code, output float_flag,
                    output digits_offset, output error_code, output error_pos,
                    input ready);
    modport sink   (input valid, input radix_code, input float_flag,
                    input digits_offset, input error_code, input error_pos,
                    output ready);
endinterface

/* design/nlc_scan.sv */
// next scan state and token result for one character
module nlc_scan
    import nlc_pkg::*;
#(
    parameter int MAX_TOKEN_LEN = NLC_MAX_TOKEN_LEN_DEF
)
(
    input  scan_state_t          cur,
    input  logic [NLC_CH_W-1:0]  ch,
    input  logic                 is_last,
    input  logic                 fp_force,
    output scan_state_t          nxt,
    output result_t              res
);

    // position saturates at the smaller of the token limit minus one and the counter range
    localparam int POS_CAP_INT = ((MAX_TOKEN_LEN - 1) < NLC_POS_MAX) ?
                                 (MAX_TOKEN_LEN - 1) : NLC_POS_MAX;
    localparam logic [NLC_POS_W-1:0] POS_CAP = NLC_POS_W'(POS_CAP_INT);

    logic        c_dec;
    logic        c_hex;
    logic        c_alpha;
    logic        c_e;
    logic        c_sign;
    logic        c_dot;
    logic        c_digit;
    logic        do_scan;
    scan_state_t pre;
    scan_state_t post;

    // character classes
    always_comb
    begin
        c_dec   = (ch >= CH_ZERO) && (ch <= CH_NINE);
        c_hex   = c_dec || ((ch >= CH_LO_A) && (ch <= CH_LO_F))
                        || ((ch >= CH_UP_A) && (ch <= CH_UP_F));
        c_alpha = ((ch >= CH_LO_A) && (ch <= CH_LO_Z))
               || ((ch >= CH_UP_A) && (ch <= CH_UP_Z));
        c_e     = (ch == CH_LO_E) || (ch == CH_UP_E);
        c_sign  = (ch == CH_PLUS) || (ch == CH_MINUS);
        c_dot   = (ch == CH_DOT);
    end

    // prefix handling on the first two characters
    always_comb
    begin
        pre     = cur;
        do_scan = 1'b0;
        case (cur.phase)
            PH_FIRST:
            begin
                pre.force_fp = fp_force;
                pre.offset   = NLC_OFS_NONE;
                pre.is_float = fp_force;
                if (ch == CH_ZERO)
                begin
                    pre.radix = fp_force ? RX_DEC : RX_OCT;
                    pre.phase = PH_ZERO;
                end
                else
                begin
                    pre.radix = RX_DEC;
                    pre.phase = PH_MAIN;
                    do_scan   = 1'b1;
                end
            end
            PH_ZERO:
            begin
                pre.phase = PH_MAIN;
                if (cur.force_fp)
                begin
                    pre.radix    = RX_DEC;
                    pre.is_float = 1'b1;
                    if (c_alpha)
                        pre.offset = NLC_OFS_PREFIX;
                    else
                        do_scan = 1'b1;
                end
                else if ((ch == CH_LO_X) || (ch == CH_UP_X))
                begin
                    pre.radix  = RX_HEX;
                    pre.offset = NLC_OFS_PREFIX;
                end
                else if ((ch == CH_LO_B) || (ch == CH_UP_B))
                begin
                    pre.radix  = RX_BIN;
                    pre.offset = NLC_OFS_PREFIX;
                end
                else if (c_alpha)
                begin
                    pre.radix    = RX_DEC;
                    pre.is_float = 1'b1;
                    pre.offset   = NLC_OFS_PREFIX;
                end
                else
                begin
                    pre.radix = RX_OCT;
                    do_scan   = 1'b1;
                end
            end
            default:
            begin
                do_scan = 1'b1;
            end
        endcase
    end

    // digit valid for the chosen radix
    always_comb
    begin
        case (pre.radix)
            RX_BIN:  c_digit = (ch == CH_ZERO) || (ch == CH_ONE);
            RX_OCT:  c_digit = (ch >= CH_ZERO) && (ch <= CH_SEVEN);
            RX_DEC:  c_digit = c_dec;
            default: c_digit = c_hex;
        endcase
    end

    // digit, fraction and exponent checking
    always_comb
    begin
        post = pre;
        if (do_scan)
        begin
            case (pre.phase)
                PH_MAIN:
                begin
                    if (c_digit)
                    begin
                        post = pre;
                    end
                    else if (c_hex && (!pre.is_float || !c_e))
                    begin
                        post.phase   = PH_DONE;
                        post.err_pos = pre.position;
                        case (pre.radix)
                            RX_BIN:  post.err_code = ERR_BAD_BIN;
                            RX_OCT:  post.err_code = ERR_BAD_OCT;
                            default: post.err_code = ERR_BAD_DEC;
                        endcase
                    end
                    else if (!pre.is_float)
                    begin
                        post.phase    = PH_DONE;
                        post.err_code = ERR_INT_SUFFIX;
                        post.err_pos  = pre.position;
                    end
                    else if (c_sign)
                    begin
                        post.phase = PH_SIGNDIG;
                    end
                    else if (c_dot)
                    begin
                        post.phase = PH_FRAC;
                    end
                    else if (c_e)
                    begin
                        post.phase   = PH_EXPSTART;
                        post.exp_pos = pre.position;
                    end
                    else
                    begin
                        post.phase    = PH_DONE;
                        post.err_code = ERR_FLOAT_SUFFIX;
                        post.err_pos  = pre.position;
                    end
                end
                PH_SIGNDIG:
                begin
                    if (c_dec)
                    begin
                        post = pre;
                    end
                    else if (c_dot)
                    begin
                        post.phase = PH_FRAC;
                    end
                    else if (c_e)
                    begin
                        post.phase   = PH_EXPSTART;
                        post.exp_pos = pre.position;
                    end
                    else
                    begin
                        post.phase    = PH_DONE;
                        post.err_code = ERR_FLOAT_SUFFIX;
                        post.err_pos  = pre.position;
                    end
                end
                PH_FRAC:
                begin
                    if (c_dec)
                    begin
                        post = pre;
                    end
                    else if (c_e)
                    begin
                        post.phase   = PH_EXPSTART;
                        post.exp_pos = pre.position;
                    end
                    else
                    begin
                        post.phase    = PH_DONE;
                        post.err_code = ERR_FLOAT_SUFFIX;
                        post.err_pos  = pre.position;
                    end
                end
                PH_EXPSTART:
                begin
                    if (c_sign)
                    begin
                        post.phase = PH_EXPSIGN;
                    end
                    else if (c_dec)
                    begin
                        post.phase = PH_EXPDIG;
                    end
                    else
                    begin
                        post.phase    = PH_DONE;
                        post.err_code = ERR_EXP_EMPTY;
                        post.err_pos  = pre.exp_pos;
                    end
                end
                PH_EXPSIGN:
                begin
                    if (c_dec)
                    begin
                        post.phase = PH_EXPDIG;
                    end
                    else
                    begin
                        post.phase    = PH_DONE;
                        post.err_code = ERR_EXP_EMPTY;
                        post.err_pos  = pre.exp_pos;
                    end
                end
                PH_EXPDIG:
                begin
                    if (!c_dec)
                    begin
                        post.phase    = PH_DONE;
                        post.err_code = ERR_FLOAT_SUFFIX;
                        post.err_pos  = pre.position;
                    end
                end
                default:
                begin
                    post = pre;
                end
            endcase
        end
    end

    // end of token: close an open exponent, report and start over
    always_comb
    begin
        res.radix    = post.radix;
        res.is_float = post.is_float;
        res.offset   = post.offset;
        res.err_code = post.err_code;
        res.err_pos  = post.err_pos;
        if ((post.phase == PH_EXPSTART) || (post.phase == PH_EXPSIGN))
        begin
            res.err_code = ERR_EXP_EMPTY;
            res.err_pos  = post.exp_pos;
        end

        if (is_last)
        begin
            nxt = SCAN_RESET;
        end
        else
        begin
            nxt = post;
            if (post.position < POS_CAP)
                nxt.position = post.position + NLC_POS_W'(1);
        end
    end

endmodule

/* design/numeric_literal_classifier.sv */
// Numeric literal classifier: takes one character of a token per beat and,
// on the beat flagged is_last, gives one result beat holding the radix, the
// float flag, the digit offset after a skipped prefix and the first error
// with its position. A new character is accepted every cycle while the skid
// entry is empty. The result is registered in the output register when free,
// else in the skid entry. The only loop is the small scan state register,
// updated once per character. Output is a result register plus one skid
// entry; input flows while a result waits, stalling only when both are full.
module numeric_literal_classifier
    import nlc_pkg::*;
#(
    parameter int MAX_TOKEN_LEN = NLC_MAX_TOKEN_LEN_DEF
)
(
    input  logic       clk,
    input  logic       rst_n,
    nlc_in_if.sink     in_chan,
    nlc_out_if.source  out_chan
);

    scan_state_t state_reg;
    scan_state_t state_next;
    result_t     res_new;
    logic        in_fire;
    logic        res_fire;
    logic        out_fire;

    logic        out_valid_reg;
    logic        out_valid_next;
    result_t     out_data_reg;
    result_t     out_data_next;
    logic        skid_valid_reg;
    logic        skid_valid_next;
    result_t     skid_data_reg;
    result_t     skid_data_next;

    nlc_scan #(
        .MAX_TOKEN_LEN (MAX_TOKEN_LEN)
    ) u_scan (
        .cur         (state_reg),
        .ch          (in_chan.ch),
        .is_last     (in_chan.is_last),
        .fp_force    (in_chan.fp_force),
        .nxt         (state_next),
        .res         (res_new)
    );

    // handshakes
    assign in_chan.ready = !skid_valid_reg;
    assign in_fire       = in_chan.valid && in_chan.ready;
    assign res_fire      = in_fire && in_chan.is_last;
    assign out_fire      = out_valid_reg && out_chan.ready;

    // scan state advances on every accepted character beat
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= SCAN_RESET;
        else if (in_fire)
            state_reg <= state_next;
    end

    // result register with one skid entry
    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_data_next   = out_data_reg;
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (!out_valid_reg || out_fire)
        begin
            if (skid_valid_reg)
            begin
                out_valid_next  = 1'b1;
                out_data_next   = skid_data_reg;
                skid_valid_next = 1'b0;
            end
            else
            begin
                out_valid_next = res_fire;
                out_data_next  = res_new;
            end
        end
        else if (res_fire)
        begin
            skid_valid_next = 1'b1;
            skid_data_next  = res_new;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg  <= out_valid_next;
            skid_valid_reg <= skid_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        out_data_reg  <= out_data_next;
        skid_data_reg <= skid_data_next;
    end

    // result beat
    assign out_chan.valid         = out_valid_reg;
    assign out_chan.radix_code    = out_data_reg.radix;
    assign out_chan.float_flag    = out_data_reg.is_float;
    assign out_chan.digits_offset = out_data_reg.offset;
    assign out_chan.error_code    = out_data_reg.err_code;
    assign out_chan.error_pos     = out_data_reg.err_pos;

endmodule

/* design/nlc_checker.sv */
// port-level checks on the classifier results
module nlc_checker
    import nlc_pkg::*;
(
    input logic                    clk,
    input logic                    rst_n,
    input logic                    out_valid,
    input logic                    out_ready,
    input logic [NLC_RADIX_W-1:0]  radix_code,
    input logic                    float_flag,
    input logic [NLC_OFS_W-1:0]    digits_offset,
    input logic [NLC_ERR_W-1:0]    error_code,
    input logic [NLC_POS_W-1:0]    error_pos
);

    // a stalled result beat holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(radix_code)
            && $stable(float_flag) && $stable(digits_offset)
            && $stable(error_code) && $stable(error_pos))
        else $error("result beat changed while stalled");

    // no error means no error position
    a_ok_pos_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && (error_code == ERR_NONE) |-> (error_pos == '0))
        else $error("error position set without an error");

    // floats are always decimal and never carry integer digit errors
    a_float_dec: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && float_flag |-> (radix_code == RX_DEC)
            && (error_code != ERR_BAD_BIN) && (error_code != ERR_BAD_OCT)
            && (error_code != ERR_INT_SUFFIX))
        else $error("float result with non-decimal radix or integer error");

    // integers never report float-only errors, and a skipped prefix means bin or hex
    a_int_errs: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !float_flag |-> (error_code != ERR_EXP_EMPTY)
            && (error_code != ERR_FLOAT_SUFFIX)
            && ((digits_offset == NLC_OFS_NONE)
                || (radix_code == RX_BIN) || (radix_code == RX_HEX)))
        else $error("integer result inconsistent with its prefix or error");

endmodule

bind numeric_literal_classifier nlc_checker u_nlc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .out_valid     (out_chan.valid),
    .out_ready     (out_chan.ready),
    .radix_code    (out_chan.radix_code),
    .float_flag    (out_chan.float_flag),
    .digits_offset (out_chan.digits_offset),
    .error_code    (out_chan.error_code),
    .error_pos     (out_chan.error_pos)
);

/* sim/nlc_tb_pkg.sv */
package nlc_tb_pkg;
    import nlc_pkg::*;

    // predicts the classification of each token and holds it until the result beat
    class literal_scoreboard;
        phase_t               phase;
        radix_t               radix;
        bit                   is_float;
        bit                   force_fp;
        bit [NLC_POS_W-1:0]   position;
        bit [NLC_OFS_W-1:0]   offset;
        err_t                 err_code;
        bit [NLC_POS_W-1:0]   err_pos;
        bit [NLC_POS_W-1:0]   exp_pos;
        bit [NLC_POS_W-1:0]   pos_cap;
        result_t              pending_results[$];
        int unsigned          errors;

        function new(int max_len);
            pos_cap = NLC_POS_W'((max_len - 1 < NLC_POS_MAX) ? max_len - 1 : NLC_POS_MAX);
            errors  = 0;
            clear();
        endfunction

        function void clear();
            phase    = PH_FIRST;
            radix    = RX_BIN;
            is_float = 1'b0;
            force_fp = 1'b0;
            position = '0;
            offset   = NLC_OFS_NONE;
            err_code = ERR_NONE;
            err_pos  = '0;
            exp_pos  = '0;
        endfunction

        task report(string msg);
            if (errors < 100)
                $display("mismatch: %s", msg);
            errors++;
        endtask

        function int unsigned pending();
            return pending_results.size();
        endfunction

        // character classes
        function bit is_dec(bit [7:0] c);
            return c >= CH_ZERO && c <= CH_NINE;
        endfunction

        function bit is_hex(bit [7:0] c);
            return is_dec(c) || (c >= CH_LO_A && c <= CH_LO_F) || (c >= CH_UP_A && c <= CH_UP_F);
        endfunction

        function bit is_alpha(bit [7:0] c);
            return (c >= CH_LO_A && c <= CH_LO_Z) || (c >= CH_UP_A && c <= CH_UP_Z);
        endfunction

        function bit is_exp(bit [7:0] c);
            return c == CH_LO_E || c == CH_UP_E;
        endfunction

        function bit in_radix(bit [7:0] c);
            case (radix)
                RX_BIN:  return c == CH_ZERO || c == CH_ONE;
                RX_OCT:  return c >= CH_ZERO && c <= CH_SEVEN;
                RX_DEC:  return is_dec(c);
                default: return is_hex(c);
            endcase
        endfunction

        // first error wins, the rest of the token is ignored
        function void raise_error(err_t code, bit [NLC_POS_W-1:0] at);
            err_code = code;
            err_pos  = at;
            phase    = PH_DONE;
        endfunction

        // what may follow a run of float digits
        function void end_of_digits(bit [7:0] c, bit [NLC_POS_W-1:0] at, bit sign_ok);
            if (sign_ok && (c == CH_PLUS || c == CH_MINUS))
                phase = PH_SIGNDIG;
            else if (c == CH_DOT)
                phase = PH_FRAC;
            else if (is_exp(c))
            begin
                exp_pos = at;
                phase   = PH_EXPSTART;
            end
            else
                raise_error(ERR_FLOAT_SUFFIX, at);
        endfunction

        // digit validation after the prefix has been settled
        function void scan(bit [7:0] c, bit [NLC_POS_W-1:0] at);
            case (phase)
                PH_MAIN:
                begin
                    if (in_radix(c))
                        return;
                    if (is_hex(c) && (!is_float || !is_exp(c)))
                    begin
                        if (radix == RX_BIN)
                            raise_error(ERR_BAD_BIN, at);
                        else if (radix == RX_OCT)
                            raise_error(ERR_BAD_OCT, at);
                        else
                            raise_error(ERR_BAD_DEC, at);
                    end
                    else if (is_float)
                        end_of_digits(c, at, 1'b1);
                    else
                        raise_error(ERR_INT_SUFFIX, at);
                end
                PH_SIGNDIG:
                begin
                    if (!is_dec(c))
                        end_of_digits(c, at, 1'b0);
                end
                PH_FRAC:
                begin
                    if (is_exp(c))
                    begin
                        exp_pos = at;
                        phase   = PH_EXPSTART;
                    end
                    else if (!is_dec(c))
                        raise_error(ERR_FLOAT_SUFFIX, at);
                end
                PH_EXPSTART:
                begin
                    if (c == CH_PLUS || c == CH_MINUS)
                        phase = PH_EXPSIGN;
                    else if (is_dec(c))
                        phase = PH_EXPDIG;
                    else
                        raise_error(ERR_EXP_EMPTY, exp_pos);
                end
                PH_EXPSIGN:
                begin
                    if (is_dec(c))
                        phase = PH_EXPDIG;
                    else
                        raise_error(ERR_EXP_EMPTY, exp_pos);
                end
                PH_EXPDIG:
                begin
                    if (!is_dec(c))
                        raise_error(ERR_FLOAT_SUFFIX, at);
                end
                default: ;
            endcase
        endfunction

        // one accepted character beat
        function void note_char(bit [7:0] c, bit last, bit ff);
            bit [NLC_POS_W-1:0] at;
            result_t            res;
            at = position;
            if (phase == PH_FIRST)
            begin
                force_fp = ff;
                offset   = NLC_OFS_NONE;
                is_float = ff;
                if (c == CH_ZERO)
                begin
                    radix = ff ? RX_DEC : RX_OCT;
                    phase = PH_ZERO;
                end
                else
                begin
                    radix = RX_DEC;
                    phase = PH_MAIN;
                    scan(c, at);
                end
            end
            else if (phase == PH_ZERO)
            begin
                phase = PH_MAIN;
                if (force_fp)
                begin
                    radix    = RX_DEC;
                    is_float = 1'b1;
                    if (is_alpha(c))
                        offset = NLC_OFS_PREFIX;
                    else
                        scan(c, at);
                end
                else if (c == CH_LO_X || c == CH_UP_X)
                begin
                    radix  = RX_HEX;
                    offset = NLC_OFS_PREFIX;
                end
                else if (c == CH_LO_B || c == CH_UP_B)
                begin
                    radix  = RX_BIN;
                    offset = NLC_OFS_PREFIX;
                end
                else if (is_alpha(c))
                begin
                    radix    = RX_DEC;
                    is_float = 1'b1;
                    offset   = NLC_OFS_PREFIX;
                end
                else
                begin
                    radix = RX_OCT;
                    scan(c, at);
                end
            end
            else
                scan(c, at);

            if (!last)
            begin
                if (position < pos_cap)
                    position++;
                return;
            end

            // an exponent still waiting for its digits
            if (phase == PH_EXPSTART || phase == PH_EXPSIGN)
                raise_error(ERR_EXP_EMPTY, exp_pos);

            res.radix    = radix;
            res.is_float = is_float;
            res.offset   = offset;
            res.err_code = err_code;
            res.err_pos  = err_pos;
            pending_results.push_back(res);
            clear();
        endfunction

        // one accepted result beat against the oldest prediction
        task check_result(logic [NLC_RADIX_W-1:0] rx, logic fl,
                          logic [NLC_OFS_W-1:0] ofs, logic [NLC_ERR_W-1:0] ec,
                          logic [NLC_POS_W-1:0] ep);
            result_t want;
            if (pending_results.size() == 0)
            begin
                report($sformatf("result beat with nothing expected (radix %0d err %0d)",
                                 rx, ec));
                return;
            end
            want = pending_results.pop_front();
            if (rx !== want.radix)
                report($sformatf("radix_code got %0d expected %0d", rx, want.radix));
            if (fl !== want.is_float)
                report($sformatf("float_flag got %0d expected %0d", fl, want.is_float));
            if (ofs !== want.offset)
                report($sformatf("digits_offset got %0d expected %0d", ofs, want.offset));
            if (ec !== want.err_code)
                report($sformatf("error_code got %0d expected %0d", ec, want.err_code));
            if (ep !== want.err_pos)
                report($sformatf("error_pos got %0d expected %0d", ep, want.err_pos));
        endtask
    endclass

endpackage

/* sim/tb_numeric_literal_classifier.sv */
module tb_numeric_literal_classifier;
    timeunit 1ns;
    timeprecision 1ps;

    import nlc_pkg::*;
    import nlc_tb_pkg::*;

    localparam int ITEM_TARGET  = 400;
    localparam int CALM_ITEMS   = 60;
    localparam int HOLD_CYCLES  = 120;
    localparam int HOLD_AFTER   = 12;
    localparam int STALL_LIMIT  = 1000;
    localparam int DRAIN_CYCLES = 10;

    logic clk = 1'b0;
    logic rst_n;

    nlc_in_if  chars_if ();
    nlc_out_if results_if ();

    numeric_literal_classifier #(
        .MAX_TOKEN_LEN (NLC_MAX_TOKEN_LEN_DEF)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_chan  (chars_if),
        .out_chan (results_if)
    );

    literal_scoreboard lit_sb;
    int unsigned       chars_sent;
    int unsigned       results_seen;
    int unsigned       stalled_cycles;
    bit                calm;
    logic [7:0]        token_text[$];

    // clock
    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // beat monitor and stall counter
    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (chars_if.valid && chars_if.ready)
                lit_sb.note_char(chars_if.ch, chars_if.is_last, chars_if.fp_force);
            if (results_if.valid && results_if.ready)
            begin
                lit_sb.check_result(results_if.radix_code, results_if.float_flag,
                                    results_if.digits_offset, results_if.error_code,
                                    results_if.error_pos);
                results_seen++;
            end
            if ((chars_if.valid && chars_if.ready) || (results_if.valid && results_if.ready))
                stalled_cycles = 0;
            else
                stalled_cycles++;
        end
    end

    // watchdog
    initial
    begin
        wait (stalled_cycles >= STALL_LIMIT);
        $display("timeout: nothing accepted for %0d cycles", STALL_LIMIT);
        $display("== FAIL ==");
        $finish;
    end

    // result side: random stall bursts, quiet stretches and one long hold-off
    initial
    begin : result_sink
        int unsigned burst_left;
        int unsigned quiet_left;
        int unsigned hold_left;
        bit          hold_done;
        burst_left = 0;
        quiet_left = 0;
        hold_left  = 0;
        hold_done  = 1'b0;
        results_if.ready <= 1'b0;
        wait (rst_n === 1'b1);
        forever
        begin
            @(posedge clk);
            if (hold_left > 0)
            begin
                hold_left--;
                results_if.ready <= 1'b0;
            end
            else if (!hold_done && results_seen >= HOLD_AFTER)
            begin
                hold_done = 1'b1;
                hold_left = HOLD_CYCLES - 1;
                results_if.ready <= 1'b0;
            end
            else if (burst_left > 0)
            begin
                burst_left--;
                results_if.ready <= 1'b0;
                if (burst_left == 0 && $urandom_range(0, 3) == 0)
                    quiet_left = $urandom_range(20, 60);
            end
            else if (!calm && quiet_left == 0 && $urandom_range(0, 5) == 0)
            begin
                burst_left = $urandom_range(0, 14);
                results_if.ready <= 1'b0;
            end
            else
            begin
                if (quiet_left > 0)
                    quiet_left--;
                results_if.ready <= 1'b1;
            end
        end
    end

    // one character beat, with an optional idle burst in front of it
    task automatic send_char(input logic [7:0] c, input bit last, input bit ff, input bit steady);
        if (!calm && !steady && $urandom_range(0, 4) == 0)
        begin
            chars_if.valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge clk);
        end
        chars_if.valid    <= 1'b1;
        chars_if.ch       <= c;
        chars_if.is_last  <= last;
        chars_if.fp_force <= ff;
        @(posedge clk);
        while (!chars_if.ready)
            @(posedge clk);
        chars_sent++;
        if (chars_sent >= ITEM_TARGET - CALM_ITEMS)
            calm = 1'b1;
    endtask

    // the float request only counts on the first character, the rest get noise
    task automatic send_token(input bit ff);
        bit steady;
        steady = ($urandom_range(0, 2) == 0);
        foreach (token_text[i])
            send_char(token_text[i], i == token_text.size() - 1,
                      (i == 0) ? ff : 1'($urandom_range(0, 1)), steady);
        token_text.delete();
    endtask

    task automatic send_text(input string s, input bit ff);
        for (int i = 0; i < s.len(); i++)
            token_text.push_back(s[i]);
        send_token(ff);
    endtask

    function automatic void add_digits(radix_t rx, int count);
        string hex_set;
        hex_set = "0123456789abcdefABCDEF";
        for (int i = 0; i < count; i++)
        begin
            case (rx)
                RX_BIN:  token_text.push_back(8'(CH_ZERO + $urandom_range(0, 1)));
                RX_OCT:  token_text.push_back(8'(CH_ZERO + $urandom_range(0, 7)));
                RX_DEC:  token_text.push_back(8'(CH_ZERO + $urandom_range(0, 9)));
                default: token_text.push_back(hex_set[$urandom_range(0, 21)]);
            endcase
        end
    endfunction

    function automatic logic [7:0] rand_letter();
        if ($urandom_range(0, 1))
            return 8'(CH_LO_A + $urandom_range(0, 25));
        return 8'(CH_UP_A + $urandom_range(0, 25));
    endfunction

    function automatic logic [7:0] rand_sign();
        return $urandom_range(0, 1) ? CH_PLUS : CH_MINUS;
    endfunction

    // digits, optional signed digits, optional fraction, optional exponent
    function automatic void add_float_body();
        add_digits(RX_DEC, $urandom_range(0, 4));
        if ($urandom_range(0, 2) == 0)
        begin
            token_text.push_back(rand_sign());
            add_digits(RX_DEC, $urandom_range(0, 3));
        end
        if ($urandom_range(0, 1))
        begin
            token_text.push_back(CH_DOT);
            add_digits(RX_DEC, $urandom_range(0, 3));
        end
        if ($urandom_range(0, 1))
        begin
            token_text.push_back($urandom_range(0, 1) ? CH_LO_E : CH_UP_E);
            if ($urandom_range(0, 1))
                token_text.push_back(rand_sign());
            add_digits(RX_DEC, ($urandom_range(0, 7) == 0) ? 0 : $urandom_range(1, 3));
        end
    endfunction

    // mostly well-formed token of a given kind with random content
    function automatic void make_token(input int kind, output bit ff);
        logic [7:0] letter;
        ff = ($urandom_range(0, 7) == 0);
        case (kind)
            0:
            begin
                token_text.push_back(CH_ZERO);
                token_text.push_back($urandom_range(0, 1) ? CH_LO_X : CH_UP_X);
                add_digits(RX_HEX, $urandom_range(0, 6));
            end
            1:
            begin
                token_text.push_back(CH_ZERO);
                token_text.push_back($urandom_range(0, 1) ? CH_LO_B : CH_UP_B);
                add_digits(RX_BIN, $urandom_range(0, 8));
            end
            2:
            begin
                token_text.push_back(CH_ZERO);
                add_digits(RX_OCT, $urandom_range(0, 5));
            end
            3:
            begin
                token_text.push_back(8'(CH_ONE + $urandom_range(0, 8)));
                add_digits(RX_DEC, $urandom_range(0, 6));
            end
            4, 5:
            begin
                ff = 1'b1;
                if ($urandom_range(0, 1))
                begin
                    token_text.push_back(CH_ZERO);
                    token_text.push_back(rand_letter());
                end
                add_float_body();
                if (token_text.size() == 0)
                    add_digits(RX_DEC, 1);
            end
            default:
            begin
                ff = 1'b0;
                do
                    letter = rand_letter();
                while (letter == CH_LO_X || letter == CH_UP_X ||
                       letter == CH_LO_B || letter == CH_UP_B);
                token_text.push_back(CH_ZERO);
                token_text.push_back(letter);
                add_float_body();
            end
        endcase
    endfunction

    // stimulus
    initial
    begin : stimulus
        bit ff;
        int kind;
        int tokens;
        int longs;
        lit_sb = new(NLC_MAX_TOKEN_LEN_DEF);
        chars_sent     = 0;
        results_seen   = 0;
        stalled_cycles = 0;
        calm           = 1'b0;
        tokens         = 0;
        longs          = 0;
        rst_n             <= 1'b0;
        chars_if.valid    <= 1'b0;
        chars_if.ch       <= '0;
        chars_if.is_last  <= 1'b0;
        chars_if.fp_force <= 1'b0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: lone zero, bare prefixes, bad digits, suffixes, empty exponent
        send_text("0", 1'b0);
        send_text("0", 1'b1);
        send_text("0x", 1'b0);
        send_text("0q", 1'b0);
        send_text("0Xf", 1'b0);
        send_text("08", 1'b0);
        send_text("0b12", 1'b0);
        send_text("1e", 1'b0);
        send_text("1.5e+", 1'b1);
        send_text("9z", 1'b1);
        token_text.push_back(8'hff);
        send_token(1'b0);
        token_text.push_back(8'h00);
        send_token(1'b1);

        // random tokens: mostly well-formed, some noise and corrupted ones
        while (chars_sent < ITEM_TARGET)
        begin
            tokens++;
            if ((tokens == 6 || tokens == 20) && longs < 2)
            begin
                // long tokens push the position into saturation
                token_text.push_back(CH_ONE);
                add_digits(RX_DEC, $urandom_range(63, 70));
                token_text.push_back(longs == 0 ? CH_LO_Z : CH_LO_E);
                ff = (longs != 0);
                longs++;
            end
            else
            begin
                kind = $urandom_range(0, 9);
                if (kind == 7)
                begin
                    repeat ($urandom_range(1, 6))
                        token_text.push_back(8'($urandom_range(0, 255)));
                    ff = 1'($urandom_range(0, 1));
                end
                else if (kind >= 8)
                begin
                    make_token($urandom_range(0, 6), ff);
                    token_text[$urandom_range(0, token_text.size() - 1)] =
                        8'($urandom_range(0, 255));
                end
                else
                    make_token(kind, ff);
            end
            send_token(ff);
        end
        chars_if.valid <= 1'b0;

        // drain
        while (lit_sb.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (lit_sb.pending() != 0)
            lit_sb.report($sformatf("%0d results never arrived", lit_sb.pending()));

        if (lit_sb.errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
